// File: sv/pbcc_pkg.sv
// ----------------------------------------------------------------------------
// pbcc_pkg
// shared types, constants and the divider step for the pitch bend to cc mapper
// ----------------------------------------------------------------------------
`default_nettype none

package pbcc_pkg;

   // midi message types (upper nibble of the status byte)
   localparam logic [3:0] PB_TYPE = 4'hE;
   localparam logic [3:0] CC_TYPE = 4'hB;

   // divider geometry
   localparam int NUM_W      = 21;
   localparam int DEN_W      = 14;
   localparam int DIV_STEPS  = 3;
   localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int QW         = DIV_STAGES * DIV_STEPS;

   // register reset values
   localparam logic [4:0]  FILTER_RESET = 5'd0;
   localparam logic        KEEP_RESET   = 1'b0;
   localparam logic [13:0] BEND_RESET   = 14'h2000;
   localparam logic [6:0]  CTL_RESET    = 7'd1;
   localparam logic [13:0] SPAN_RESET   = 14'd16256;

   typedef enum logic [2:0] {
      REG_FILTER_CHANNEL = 3'd0,
      REG_KEEP_ORIGINAL  = 3'd1,
      REG_BEND_LOW       = 3'd2,
      REG_BEND_HIGH      = 3'd3,
      REG_POS_CONTROLLER = 3'd4,
      REG_NEG_CONTROLLER = 3'd5,
      REG_POS_SPAN       = 3'd6,
      REG_NEG_SPAN       = 3'd7
   } reg_index_type;

   // per transaction data carried alongside the arithmetic
   typedef struct packed {
      logic [7:0]  status;
      logic [7:0]  first;
      logic [7:0]  second;
      logic [15:0] time_offset;
      logic        final_event;
      logic        hit;
      logic        keep;
      logic [6:0]  ctl;
      logic [6:0]  lo;
      logic        zero;
      logic        neg;
   } meta_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [QW-1:0]    nq;
   } div_state_type;

   // one restoring division step: numerator bits shift out, quotient bits in
   function automatic div_state_type div_step(input div_state_type s,
                                              input logic [DEN_W-1:0] d);
      logic [DEN_W:0] t;
      logic           ge;
      div_state_type  r;
      t     = {s.rem, s.nq[QW-1]};
      ge    = t >= {1'b0, d};
      r.rem = ge ? DEN_W'(t - {1'b0, d}) : t[DEN_W-1:0];
      r.nq  = {s.nq[QW-2:0], ge};
      return r;
   endfunction

endpackage

`default_nettype wire

// File: sv/pbcc_div_pipe.sv
// ----------------------------------------------------------------------------
// pbcc_div_pipe
// pipelined unsigned restoring divider, a few quotient bits per stage
// ----------------------------------------------------------------------------
`default_nettype none

module pbcc_div_pipe (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire logic [pbcc_pkg::QW-1:0]    in_num,
   input  wire logic [pbcc_pkg::DEN_W-1:0] in_den,
   input  wire pbcc_pkg::meta_type      in_meta,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output logic [pbcc_pkg::QW-1:0]      out_quot,
   output pbcc_pkg::meta_type           out_meta
);

   import pbcc_pkg::*;

   logic          v_ff   [DIV_STAGES];
   div_state_type s_ff   [DIV_STAGES];
   logic [DEN_W-1:0] d_ff [DIV_STAGES];
   meta_type      m_ff   [DIV_STAGES];

   logic          rdy    [DIV_STAGES];
   div_state_type src_s  [DIV_STAGES];
   logic [DEN_W-1:0] src_d [DIV_STAGES];
   meta_type      src_m  [DIV_STAGES];
   logic          src_v  [DIV_STAGES];
   div_state_type s_in   [DIV_STAGES];

   // ready ripples back from the output
   always_comb begin
      rdy[DIV_STAGES-1] = !v_ff[DIV_STAGES-1] || out_ready;
      for (int k = DIV_STAGES - 2; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   always_comb begin
      src_s[0] = '{rem: '0, nq: in_num};
      src_d[0] = in_den;
      src_m[0] = in_meta;
      src_v[0] = in_valid;
      for (int k = 1; k < DIV_STAGES; k++) begin
         src_s[k] = s_ff[k-1];
         src_d[k] = d_ff[k-1];
         src_m[k] = m_ff[k-1];
         src_v[k] = v_ff[k-1];
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
         s_in[k] = src_s[k];
         for (int j = 0; j < DIV_STEPS; j++) begin
            s_in[k] = div_step(s_in[k], src_d[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= src_v[k];
         end
         if (rdy[k]) begin
            s_ff[k] <= s_in[k];
            d_ff[k] <= src_d[k];
            m_ff[k] <= src_m[k];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[DIV_STAGES-1];
   assign out_quot  = s_ff[DIV_STAGES-1].nq;
   assign out_meta  = m_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

// File: sv/midi_pitch_bend_to_cc_mapper_top.sv
// path: stage 1, 2 and 3 registers, then the divider stages, then the output register
// throughput: one input per cycle without rsp_stall; an input that yields a control
//   change and the original bend holds the single output register until both go out
// reset: synchronous; clears the pipeline valid bits and loads the register defaults
// ----------------------------------------------------------------------------
// midi_pitch_bend_to_cc_mapper_top
// maps in-range pitch bend events to control changes, passes other events through
// ----------------------------------------------------------------------------
`default_nettype none

module midi_pitch_bend_to_cc_mapper_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_status_byte,
   input  wire logic [7:0]  req_first_data,
   input  wire logic [7:0]  req_second_data,
   input  wire logic [15:0] req_time_offset,
   input  wire logic        req_final_event,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_status_out,
   output logic [7:0]       rsp_first_data_out,
   output logic [7:0]       rsp_second_data_out,
   output logic [15:0]      rsp_time_offset_out,
   output logic             rsp_last_of_run,
   output logic             rsp_block_end,
   // register port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   import pbcc_pkg::*;

   // registers
   logic [4:0]         filter_channel_ff;
   logic               keep_original_ff;
   logic signed [13:0] bend_low_ff;
   logic signed [13:0] bend_high_ff;
   logic [6:0]         pos_controller_ff;
   logic [6:0]         neg_controller_ff;
   logic [13:0]        pos_span_ff;
   logic [13:0]        neg_span_ff;

   reg_index_type csr_index;
   logic          csr_write;

   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[4:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_channel_ff <= FILTER_RESET;
         keep_original_ff  <= KEEP_RESET;
         bend_low_ff       <= BEND_RESET;
         bend_high_ff      <= BEND_RESET;
         pos_controller_ff <= CTL_RESET;
         neg_controller_ff <= CTL_RESET;
         pos_span_ff       <= SPAN_RESET;
         neg_span_ff       <= SPAN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_FILTER_CHANNEL: filter_channel_ff <= pwdata[4:0];
            REG_KEEP_ORIGINAL:  keep_original_ff  <= pwdata[0];
            REG_BEND_LOW:       bend_low_ff       <= pwdata[13:0];
            REG_BEND_HIGH:      bend_high_ff      <= pwdata[13:0];
            REG_POS_CONTROLLER: pos_controller_ff <= pwdata[6:0];
            REG_NEG_CONTROLLER: neg_controller_ff <= pwdata[6:0];
            REG_POS_SPAN:       pos_span_ff       <= pwdata[13:0];
            REG_NEG_SPAN:       neg_span_ff       <= pwdata[13:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_FILTER_CHANNEL: prdata = {27'd0, filter_channel_ff};
         REG_KEEP_ORIGINAL:  prdata = {31'd0, keep_original_ff};
         REG_BEND_LOW:       prdata = {18'd0, bend_low_ff};
         REG_BEND_HIGH:      prdata = {18'd0, bend_high_ff};
         REG_POS_CONTROLLER: prdata = {25'd0, pos_controller_ff};
         REG_NEG_CONTROLLER: prdata = {25'd0, neg_controller_ff};
         REG_POS_SPAN:       prdata = {18'd0, pos_span_ff};
         REG_NEG_SPAN:       prdata = {18'd0, neg_span_ff};
         default:            prdata = '0;
      endcase
   end

   // stage 1: decode, range check, mapping end points
   logic               s1_v_ff;
   meta_type           s1_m_ff;
   logic signed [14:0] s1_dx_ff;
   logic signed [14:0] s1_db_ff;
   logic signed [7:0]  s1_dh_ff;

   logic               s1_rdy;
   meta_type           s1_m_in;
   logic signed [14:0] s1_dx_in;
   logic signed [14:0] s1_db_in;
   logic signed [7:0]  s1_dh_in;
   logic signed [13:0] bv;
   logic signed [13:0] lo_b;
   logic signed [13:0] hi_b;
   logic signed [14:0] v15;
   logic signed [14:0] mn15;
   logic signed [14:0] mx15;
   logic signed [14:0] a15;
   logic signed [14:0] b15;
   logic [4:0]         sel;
   logic [13:0]        span;
   logic               le;
   logic               pos;
   logic               chan_ok;
   logic               is_pb;

   always_comb begin
      bv      = {~req_second_data[6], req_second_data[5:0], req_first_data[6:0]};
      le      = bend_low_ff <= bend_high_ff;
      lo_b    = le ? bend_low_ff : bend_high_ff;
      hi_b    = le ? bend_high_ff : bend_low_ff;
      sel     = (filter_channel_ff > 5'd16) ? 5'd16 : filter_channel_ff;
      chan_ok = (sel == 5'd0) || ({1'b0, req_status_byte[3:0]} == 5'(sel - 5'd1));
      is_pb   = req_status_byte[7:4] == PB_TYPE;
      pos     = !bv[13];
      v15     = {bv[13], bv};
      mn15    = {bend_low_ff[13], bend_low_ff};
      mx15    = {bend_high_ff[13], bend_high_ff};
      if (pos && le) begin
         a15 = 15'sd0;
         b15 = mx15;
      end else if (pos) begin
         a15 = mn15;
         b15 = 15'sd8191;
      end else if (le) begin
         a15 = -15'sd1;
         b15 = mn15;
      end else begin
         a15 = mx15;
         b15 = -15'sd8192;
      end
      s1_dx_in = v15 - a15;
      s1_db_in = b15 - a15;
      span     = pos ? pos_span_ff : neg_span_ff;
      s1_dh_in = $signed({1'b0, span[13:7]}) - $signed({1'b0, span[6:0]});

      s1_m_in.status      = req_status_byte;
      s1_m_in.first       = req_first_data;
      s1_m_in.second      = req_second_data;
      s1_m_in.time_offset = req_time_offset;
      s1_m_in.final_event = req_final_event;
      s1_m_in.hit         = is_pb && chan_ok && (bv >= lo_b) && (bv <= hi_b);
      s1_m_in.keep        = keep_original_ff;
      s1_m_in.ctl         = pos ? pos_controller_ff : neg_controller_ff;
      s1_m_in.lo          = span[6:0];
      s1_m_in.zero        = 1'b0;
      s1_m_in.neg         = 1'b0;
   end

   // stage 2: product of the offsets
   logic               s2_v_ff;
   meta_type           s2_m_ff;
   logic signed [22:0] s2_prod_ff;
   logic signed [14:0] s2_db_ff;
   logic               s2_rdy;
   logic signed [22:0] s2_prod_in;

   assign s2_prod_in = s1_dx_ff * s1_dh_ff;

   // stage 3: magnitudes and quotient sign
   logic               s3_v_ff;
   meta_type           s3_m_ff;
   logic [QW-1:0]      s3_num_ff;
   logic [DEN_W-1:0]   s3_den_ff;
   logic               s3_rdy;
   meta_type           s3_m_in;
   logic [22:0]        pabs;
   logic [14:0]        dabs;

   always_comb begin
      pabs         = s2_prod_ff[22] ? 23'(-s2_prod_ff) : s2_prod_ff;
      dabs         = s2_db_ff[14] ? 15'(-s2_db_ff) : s2_db_ff;
      s3_m_in      = s2_m_ff;
      s3_m_in.zero = s2_db_ff == 15'sd0;
      s3_m_in.neg  = s2_prod_ff[22] ^ s2_db_ff[14];
   end

   // divider
   logic          div_in_ready;
   logic          div_out_valid;
   logic [QW-1:0] div_quot;
   meta_type      div_meta;
   logic          o_rdy;

   pbcc_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_v_ff),
      .in_ready  (div_in_ready),
      .in_num    (s3_num_ff),
      .in_den    (s3_den_ff),
      .in_meta   (s3_m_ff),
      .out_valid (div_out_valid),
      .out_ready (o_rdy),
      .out_quot  (div_quot),
      .out_meta  (div_meta)
   );

   // output register with the final mapping
   logic       o_v_ff;
   meta_type   o_m_ff;
   logic [6:0] o_val_ff;
   logic       o_ph_ff;
   logic [6:0] q7;
   logic [6:0] o_val_in;
   logic       cc_first;
   logic       rsp_take;

   always_comb begin
      q7       = div_quot[6:0];
      o_val_in = div_meta.zero ? div_meta.lo
               : 7'(div_meta.lo + (div_meta.neg ? 7'(-q7) : q7));
   end

   assign cc_first        = o_m_ff.hit && !o_ph_ff;
   assign rsp_valid       = o_v_ff;
   assign rsp_status_out  = cc_first ? {CC_TYPE, o_m_ff.status[3:0]} : o_m_ff.status;
   assign rsp_first_data_out  = cc_first ? {1'b0, o_m_ff.ctl} : o_m_ff.first;
   assign rsp_second_data_out = cc_first ? {1'b0, o_val_ff} : o_m_ff.second;
   assign rsp_time_offset_out = o_m_ff.time_offset;
   assign rsp_last_of_run = !(cc_first && o_m_ff.keep);
   assign rsp_block_end   = rsp_last_of_run && o_m_ff.final_event;
   assign rsp_take        = o_v_ff && !rsp_stall;

   // ready chain
   assign o_rdy     = !o_v_ff || (rsp_take && rsp_last_of_run);
   assign s3_rdy    = !s3_v_ff || div_in_ready;
   assign s2_rdy    = !s2_v_ff || s3_rdy;
   assign s1_rdy    = !s1_v_ff || s2_rdy;
   assign req_stall = !s1_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         o_v_ff  <= 1'b0;
         o_ph_ff <= 1'b0;
      end else begin
         if (s1_rdy) begin
            s1_v_ff <= req_valid;
         end
         if (s2_rdy) begin
            s2_v_ff <= s1_v_ff;
         end
         if (s3_rdy) begin
            s3_v_ff <= s2_v_ff;
         end
         if (o_rdy) begin
            o_v_ff  <= div_out_valid;
            o_ph_ff <= 1'b0;
         end else if (rsp_take) begin
            o_ph_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_m_ff  <= s1_m_in;
         s1_dx_ff <= s1_dx_in;
         s1_db_ff <= s1_db_in;
         s1_dh_ff <= s1_dh_in;
      end
      if (s2_rdy) begin
         s2_m_ff    <= s1_m_ff;
         s2_prod_ff <= s2_prod_in;
         s2_db_ff   <= s1_db_ff;
      end
      if (s3_rdy) begin
         s3_m_ff   <= s3_m_in;
         s3_num_ff <= pabs[QW-1:0];
         s3_den_ff <= dabs[DEN_W-1:0];
      end
      if (o_rdy) begin
         o_m_ff   <= div_meta;
         o_val_ff <= o_val_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/pbcc_checker.sv
// ----------------------------------------------------------------------------
// pbcc_checker
// port level checks on the result channel of the pitch bend to cc mapper
// ----------------------------------------------------------------------------
`default_nettype none

module pbcc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_status_out,
   input wire logic [15:0] rsp_time_offset_out,
   input wire logic        rsp_last_of_run,
   input wire logic        rsp_block_end
);

   import pbcc_pkg::*;

   // block end only on the last result of a run
   a_block_end_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_end |-> rsp_last_of_run)
      else $error("block_end without last_of_run");

   // the first of a result pair is always the control change
   a_pair_first_cc : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> rsp_status_out[7:4] == CC_TYPE)
      else $error("non-final result is not a control change");

   // the original bend follows its control change at once with the same offset
   a_pair_second : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_run |=>
         rsp_valid && rsp_last_of_run && $stable(rsp_time_offset_out))
      else $error("second result of a pair missing");

   // stalled transaction holds
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status_out))
      else $error("stalled result changed");

   // nothing comes out right after reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind midi_pitch_bend_to_cc_mapper_top pbcc_checker u_pbcc_checker (.*);

`default_nettype wire

// File: tb/midi_pitch_bend_to_cc_mapper_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midi_pitch_bend_to_cc_mapper_top_tb
// drives midi events into the mapper with random gaps and output stalls,
// predicts the control change and pass-through results from a local copy of
// the registers and checks every result transaction field by field
// ----------------------------------------------------------------------------

module midi_pitch_bend_to_cc_mapper_top_tb;

   import pbcc_pkg::*;

   localparam int LONG_HOLD   = 400;
   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic [7:0]  status;
      logic [7:0]  first;
      logic [7:0]  second;
      logic [15:0] offset;
      logic        fin;
      logic        sync;
   } midi_event_type;

   typedef struct packed {
      logic [7:0]  status;
      logic [7:0]  first;
      logic [7:0]  second;
      logic [15:0] offset;
      logic        last;
      logic        blk;
   } midi_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_status_byte = '0;
   logic [7:0]  req_first_data = '0;
   logic [7:0]  req_second_data = '0;
   logic [15:0] req_time_offset = '0;
   logic        req_final_event = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_status_out;
   logic [7:0]  rsp_first_data_out;
   logic [7:0]  rsp_second_data_out;
   logic [15:0] rsp_time_offset_out;
   logic        rsp_last_of_run;
   logic        rsp_block_end;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // local copy of the register file
   logic [4:0]  cfg_filter = FILTER_RESET;
   logic        cfg_keep = KEEP_RESET;
   logic [13:0] cfg_bend_low = BEND_RESET;
   logic [13:0] cfg_bend_high = BEND_RESET;
   logic [6:0]  cfg_pos_ctl = CTL_RESET;
   logic [6:0]  cfg_neg_ctl = CTL_RESET;
   logic [13:0] cfg_pos_span = SPAN_RESET;
   logic [13:0] cfg_neg_span = SPAN_RESET;

   midi_event_type  pending_events[$];
   midi_result_type expected_events[$];
   midi_event_type  on_wire;

   int send_mode = 1;
   int recv_mode = 1;
   int send_gap = 0;
   int hold_left = 0;
   int long_left = 0;
   logic hold_request = 1'b0;

   int errors = 0;
   int events_in = 0;
   int results_checked = 0;
   int bends_mapped = 0;
   int settings_used = 1;
   int cycles = 0;

   midi_pitch_bend_to_cc_mapper_top uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_status_byte(req_status_byte),
      .req_first_data(req_first_data),
      .req_second_data(req_second_data),
      .req_time_offset(req_time_offset),
      .req_final_event(req_final_event),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status_out(rsp_status_out),
      .rsp_first_data_out(rsp_first_data_out),
      .rsp_second_data_out(rsp_second_data_out),
      .rsp_time_offset_out(rsp_time_offset_out),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_block_end(rsp_block_end),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   function automatic int idle_cycles(input int mode);
      if (mode == 0) return 0;
      if (mode == 2 && $urandom_range(0, 7) != 0) return 0;
      return $urandom_range(0, 10);
   endfunction

   function automatic midi_result_type make_result(input logic [7:0] st,
                                                   input logic [7:0] d1,
                                                   input logic [7:0] d2,
                                                   input logic [15:0] off,
                                                   input logic last, input logic fin);
      midi_result_type r;
      r.status = st;
      r.first  = d1;
      r.second = d2;
      r.offset = off;
      r.last   = last;
      r.blk    = last & fin;
      return r;
   endfunction

   function automatic logic [6:0] scale_bend(input int x, input int a, input int b,
                                             input int lo, input int hi);
      int r;
      if (b == a) r = lo;
      else r = lo + ((x - a) * (hi - lo)) / (b - a);
      return r[6:0];
   endfunction

   function automatic void predict_events(input midi_event_type ev);
      int sel, chan, bend, mn, mx, lo_b, hi_b, lo, hi;
      logic [6:0] ctl, val;
      sel  = (cfg_filter > 5'd16) ? 16 : int'(cfg_filter);
      chan = ev.status[3:0];
      bend = {ev.second[6:0], ev.first[6:0]};
      bend = bend - 8192;
      mn   = $signed(cfg_bend_low);
      mx   = $signed(cfg_bend_high);
      lo_b = (mn < mx) ? mn : mx;
      hi_b = (mn < mx) ? mx : mn;
      if (ev.status[7:4] != PB_TYPE || (sel != 0 && chan != sel - 1) ||
          bend < lo_b || bend > hi_b) begin
         expected_events.push_back(make_result(ev.status, ev.first, ev.second, ev.offset,
                                               1'b1, ev.fin));
         return;
      end
      if (bend >= 0) begin
         lo  = cfg_pos_span[6:0];
         hi  = cfg_pos_span[13:7];
         ctl = cfg_pos_ctl;
         val = (mn <= mx) ? scale_bend(bend, 0, mx, lo, hi) : scale_bend(bend, mn, 8191, lo, hi);
      end else begin
         lo  = cfg_neg_span[6:0];
         hi  = cfg_neg_span[13:7];
         ctl = cfg_neg_ctl;
         val = (mn <= mx) ? scale_bend(bend, -1, mn, lo, hi)
                          : scale_bend(bend, mx, -8192, lo, hi);
      end
      bends_mapped++;
      expected_events.push_back(make_result({CC_TYPE, ev.status[3:0]}, {1'b0, ctl},
                                            {1'b0, val}, ev.offset, !cfg_keep, ev.fin));
      if (cfg_keep)
         expected_events.push_back(make_result(ev.status, ev.first, ev.second, ev.offset,
                                               1'b1, ev.fin));
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s expected %0h actual %0h", name, want, got);
         errors++;
      end
   endfunction

   // driver
   always @(posedge clock) begin : drive_events
      logic next_valid;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_events(on_wire);
            events_in++;
            next_valid = 1'b0;
            send_gap = idle_cycles(send_mode);
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_events.size() > 0 &&
                         (!pending_events[0].sync || expected_events.size() == 0)) begin
               on_wire = pending_events.pop_front();
               req_status_byte <= on_wire.status;
               req_first_data  <= on_wire.first;
               req_second_data <= on_wire.second;
               req_time_offset <= on_wire.offset;
               req_final_event <= on_wire.fin;
               next_valid = 1'b1;
            end
         end
      end
      req_valid <= next_valid;
   end

   // monitor
   always @(posedge clock) begin : watch_results
      midi_result_type want;
      logic next_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               $error("unexpected result transaction, status %02h", rsp_status_out);
               errors++;
            end else begin
               want = expected_events.pop_front();
               check_field("status_out", want.status, rsp_status_out);
               check_field("first_data_out", want.first, rsp_first_data_out);
               check_field("second_data_out", want.second, rsp_second_data_out);
               check_field("time_offset_out", want.offset, rsp_time_offset_out);
               check_field("last_of_run", want.last, rsp_last_of_run);
               check_field("block_end", want.blk, rsp_block_end);
               results_checked++;
            end
            hold_left = idle_cycles(recv_mode);
         end
         if (hold_request) begin
            long_left = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (long_left > 0) begin
            long_left--;
            next_stall = 1'b1;
         end else if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
         end else begin
            next_stall = 1'b0;
         end
         rsp_stall <= next_stall;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("midi_pitch_bend_to_cc_mapper_top_tb NOT OK");
         $finish;
      end
   end

   task automatic csr_write(input reg_index_type idx, input int width, input logic [31:0] value);
      logic [31:0] junk;
      junk = $urandom();
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= (junk << width) | (value & ((32'd1 << width) - 1));
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic program_setting(input logic [4:0] f, input logic k,
                                  input logic [13:0] bl, input logic [13:0] bh,
                                  input logic [6:0] pc, input logic [6:0] nc,
                                  input logic [13:0] ps, input logic [13:0] ns);
      csr_write(REG_FILTER_CHANNEL, 5, f);
      csr_write(REG_KEEP_ORIGINAL, 1, k);
      csr_write(REG_BEND_LOW, 14, bl);
      csr_write(REG_BEND_HIGH, 14, bh);
      csr_write(REG_POS_CONTROLLER, 7, pc);
      csr_write(REG_NEG_CONTROLLER, 7, nc);
      csr_write(REG_POS_SPAN, 14, ps);
      csr_write(REG_NEG_SPAN, 14, ns);
      cfg_filter    = f;
      cfg_keep      = k;
      cfg_bend_low  = bl;
      cfg_bend_high = bh;
      cfg_pos_ctl   = pc;
      cfg_neg_ctl   = nc;
      cfg_pos_span  = ps;
      cfg_neg_span  = ns;
      settings_used++;
   endtask

   task automatic queue_event(input logic [7:0] st, input logic [7:0] d1, input logic [7:0] d2,
                              input logic [15:0] off, input logic fin, input logic sync);
      midi_event_type ev;
      ev.status = st;
      ev.first  = d1;
      ev.second = d2;
      ev.offset = off;
      ev.fin    = fin;
      ev.sync   = sync;
      pending_events.push_back(ev);
   endtask

   task automatic queue_bend(input logic [3:0] chan, input int v, input logic [15:0] off,
                             input logic fin, input logic sync);
      logic [13:0] u;
      u = 14'(v + 8192);
      queue_event({PB_TYPE, chan}, {1'($urandom()), u[6:0]}, {1'($urandom()), u[13:7]},
                  off, fin, sync);
   endtask

   task automatic queue_random_events(input int count);
      int i, sel, mn, mx, lo_b, hi_b, v;
      logic [3:0] chan;
      sel  = (cfg_filter > 5'd16) ? 16 : int'(cfg_filter);
      mn   = $signed(cfg_bend_low);
      mx   = $signed(cfg_bend_high);
      lo_b = (mn < mx) ? mn : mx;
      hi_b = (mn < mx) ? mx : mn;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) != 0) begin
            if (sel != 0 && $urandom_range(0, 3) != 0) chan = 4'(sel - 1);
            else chan = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 4) != 0) v = lo_b + int'($urandom_range(0, hi_b - lo_b));
            else v = int'($urandom_range(0, 16383)) - 8192;
            queue_bend(chan, v, 16'($urandom()), $urandom_range(0, 7) == 0, (i % 150) == 149);
         end else begin
            queue_event(8'($urandom()), 8'($urandom()), 8'($urandom()), 16'($urandom()),
                        $urandom_range(0, 7) == 0, (i % 150) == 149);
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_events.size() != 0 || req_valid || expected_events.size() != 0)
         @(posedge clock);
   endtask

   initial begin : stimulus
      int ph;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: only a full negative bend is in range
      queue_event(8'hE0, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b0);
      queue_event(8'hE5, 8'h7F, 8'h7F, 16'hFFFF, 1'b0, 1'b0);
      queue_event(8'h90, 8'h3C, 8'h64, 16'h1234, 1'b0, 1'b0);
      queue_event(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 1'b0);
      queue_event(8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b0);
      wait_drained();

      // full range, original kept
      program_setting(5'd0, 1'b1, 14'h2000, 14'h1FFF, 7'd127, 7'd0, 14'h3F80, 14'h007F);
      queue_event(8'hE0, 8'h00, 8'h00, 16'h0001, 1'b0, 1'b0);
      queue_event(8'hE1, 8'h7F, 8'h3F, 16'h0002, 1'b1, 1'b0);
      queue_event(8'hE2, 8'h00, 8'h40, 16'h0003, 1'b0, 1'b0);
      queue_event(8'hEF, 8'h7F, 8'h7F, 16'hFFFF, 1'b1, 1'b0);
      queue_event(8'hE3, 8'hFF, 8'hFF, 16'h8000, 1'b0, 1'b0);
      queue_event(8'hE7, 8'h80, 8'hC0, 16'h0000, 1'b1, 1'b0);
      queue_event(8'hB0, 8'h07, 8'h40, 16'h0100, 1'b0, 1'b0);
      wait_drained();

      // swapped bounds, channel selector above 16
      program_setting(5'd31, 1'b0, 14'(4000), 14'(-4000), 7'd5, 7'd6, 14'h1234, 14'h2BCD);
      queue_bend(4'hF, 5000, 16'h0010, 1'b0, 1'b0);
      queue_bend(4'hF, 100, 16'h0011, 1'b1, 1'b0);
      queue_bend(4'hF, -100, 16'h0012, 1'b0, 1'b0);
      queue_bend(4'hF, 4000, 16'h0013, 1'b0, 1'b0);
      queue_bend(4'hF, -4000, 16'h0014, 1'b1, 1'b0);
      queue_bend(4'h0, 0, 16'h0015, 1'b0, 1'b0);
      wait_drained();

      // zero-width input span on both sides
      program_setting(5'd16, 1'b1, 14'h1FFF, 14'h2000, 7'd0, 7'd127, 14'h3FFF, 14'h0000);
      queue_bend(4'hF, 8191, 16'h0020, 1'b1, 1'b0);
      queue_bend(4'hF, -8192, 16'h0021, 1'b0, 1'b0);
      queue_bend(4'hF, 0, 16'h0022, 1'b0, 1'b0);
      queue_bend(4'h0, 0, 16'h0023, 1'b1, 1'b0);

      for (ph = 0; ph < 6; ph++) begin
         wait_drained();
         case (ph)
            0: program_setting(5'd16, 1'b1, 14'h2000, 14'h1FFF, 7'd127, 7'd0,
                               14'h3FFF, 14'h0000);
            1: program_setting(5'd0, 1'b0, 14'h1FFF, 14'h2000, 7'd0, 7'd127,
                               14'h0000, 14'h3FFF);
            default: program_setting(5'($urandom_range(0, 31)), 1'($urandom()),
                                     14'($urandom()), 14'($urandom()), 7'($urandom()),
                                     7'($urandom()), 14'($urandom()), 14'($urandom()));
         endcase
         send_mode = (ph == 2) ? 0 : $urandom_range(0, 2);
         recv_mode = (ph == 2) ? 1 : $urandom_range(0, 2);
         queue_random_events(300);
         if (ph == 2) begin
            // long receiver hold-off while the sender keeps going
            @(negedge clock);
            hold_request = 1'b1;
         end
      end
      wait_drained();
      repeat (30) @(posedge clock);

      $display("run covered %0d events, %0d bends mapped to control changes, %0d settings",
               events_in, bends_mapped, settings_used);
      $display("%0d result transactions checked, %0d mismatches", results_checked, errors);
      if (errors == 0) begin
         $display("midi_pitch_bend_to_cc_mapper_top_tb OK");
      end else begin
         $display("midi_pitch_bend_to_cc_mapper_top_tb NOT OK");
      end
      $finish;
   end

endmodule
